// ----- src/utt_pkg.sv -----
// Shared types, constants and the UTF-8 encoder function for the UTF-16 to UTF-8 transcoder.
// Used by the config interface, the top level and every utt_* module; depends on nothing.
package utt_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOrder    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReplByte = 2'd2;
  localparam logic [CfgIdxW-1:0] RegReplLen  = 2'd3;

  // Validation modes (code 3 behaves as stop)
  localparam logic [1:0] ModeStop    = 2'd0;
  localparam logic [1:0] ModeSkip    = 2'd1;
  localparam logic [1:0] ModeReplace = 2'd2;

  localparam logic [31:0] ReplBytesReset = 32'h00BD_BFEF;
  localparam logic [2:0]  ReplLenReset   = 3'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic        order;
    logic [31:0] repl_bytes;
    logic [2:0]  repl_len;
  } cfg_t;

  // One queued job: up to four bytes, or a single status-only result
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            byte_valid;
    logic            inv;
    logic            stop;
    logic            eos;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.last_idx = 2'd0;
    end else if (cp < 21'h800) begin
      e.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

endpackage

// ----- src/utt_if.sv -----
// Valid/ready channel interfaces: UTF-16 unit input, UTF-8 byte output, config writes.
// Depends on utt_pkg for the config field widths.
interface utt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_pair;
  logic        last_unit;
  modport source (output valid, raw_pair, last_unit, input ready);
  modport sink (input valid, raw_pair, last_unit, output ready);
endinterface

interface utt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       invalid_seen;
  logic       error_stop;
  logic       end_of_stream;
  modport source (output valid, out_byte, byte_valid, last_of_run, invalid_seen,
                  error_stop, end_of_stream, input ready);
  modport sink (input valid, out_byte, byte_valid, last_of_run, invalid_seen,
                error_stop, end_of_stream, output ready);
endinterface

interface utt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [utt_pkg::CfgIdxW-1:0]   index;
  logic [utt_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/utf16_to_utf8_transcoder.sv -----
// UTF-16 to UTF-8 transcoder top level: config registers, front end, job queue, sequencer.
// An accepted unit goes into the job queue, then its first byte into the output register.
// Throughput: one unit per cycle in unless the queue is full, one byte per cycle out unless
// stalled; a unit's N bytes (up to 4) hold the sequencer, the 2-entry queue absorbs the rest.
// Reset (rst_ni low, async): stream state, queue and output valid cleared; config to defaults.
// Depends on utt_pkg, utt_if, utt_front, utt_job_fifo, utt_back.
module utf16_to_utf8_transcoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  utt_cfg_if.sink   cfg_i,
  utt_in_if.sink    in_i,
  utt_out_if.source out_o
);

  utt_pkg::cfg_t cfg_q;
  utt_pkg::job_t push_job, head_job;
  logic          push, q_full, pop, head_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= utt_pkg::ModeStop;
      cfg_q.order      <= 1'b0;
      cfg_q.repl_bytes <= utt_pkg::ReplBytesReset;
      cfg_q.repl_len   <= utt_pkg::ReplLenReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        utt_pkg::RegMode:     cfg_q.mode       <= cfg_i.data[1:0];
        utt_pkg::RegOrder:    cfg_q.order      <= cfg_i.data[0];
        utt_pkg::RegReplByte: cfg_q.repl_bytes <= cfg_i.data;
        utt_pkg::RegReplLen:  cfg_q.repl_len   <= cfg_i.data[2:0];
        default:              cfg_q            <= cfg_q;
      endcase
    end
  end

  utt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .raw_pair_i  (in_i.raw_pair),
    .last_unit_i (in_i.last_unit),
    .push_o      (push),
    .job_o       (push_job),
    .q_full_i    (q_full)
  );

  utt_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  utt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .byte_valid_o    (out_o.byte_valid),
    .last_of_run_o   (out_o.last_of_run),
    .invalid_seen_o  (out_o.invalid_seen),
    .error_stop_o    (out_o.error_stop),
    .end_of_stream_o (out_o.end_of_stream)
  );

endmodule

// ----- src/utt_front.sv -----
// Front end: accepts UTF-16 units, tracks surrogate/stream state, builds output jobs.
// Depends on utt_pkg (cfg_t, job_t, encode_cp).
module utt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  utt_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       raw_pair_i,
  input  logic              last_unit_i,
  output logic              push_o,
  output utt_pkg::job_t     job_o,
  input  logic              q_full_i
);

  logic       lead_q, lead_d;
  logic [9:0] held_q, held_d;
  logic       sticky_q, sticky_d;
  logic       halted_q, halted_d;

  logic [15:0]   unit;
  logic          accept;
  logic          is_lead, is_trail;
  logic          invalid, end_lead, have_cp, stop;
  logic [20:0]   cp;
  utt_pkg::enc_t enc;
  logic [1:0]    repl_last;
  logic          have_bytes;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign unit       = cfg_i.order ? {raw_pair_i[7:0], raw_pair_i[15:8]} : raw_pair_i;
  assign is_lead    = (unit[15:10] == 6'b110110);
  assign is_trail   = (unit[15:10] == 6'b110111);
  assign enc        = utt_pkg::encode_cp(cp);

  always_comb begin
    case (cfg_i.repl_len)
      3'd0, 3'd1: repl_last = 2'd0;
      3'd2:       repl_last = 2'd1;
      3'd3:       repl_last = 2'd2;
      default:    repl_last = 2'd3;
    endcase
  end

  always_comb begin
    lead_d     = lead_q;
    held_d     = held_q;
    sticky_d   = sticky_q;
    halted_d   = halted_q;
    invalid    = 1'b0;
    end_lead   = 1'b0;
    have_cp    = 1'b0;
    stop       = 1'b0;
    have_bytes = 1'b0;
    cp         = {5'b0, unit};
    push_o     = 1'b0;
    job_o      = '0;

    if (halted_q) begin
      if (last_unit_i) begin
        push_o       = accept;
        job_o.inv    = sticky_q;
        job_o.stop   = 1'b1;
        job_o.eos    = 1'b1;
      end
    end else begin
      if (lead_q) begin
        lead_d = 1'b0;
        held_d = '0;
        if (is_trail) begin
          cp      = 21'h10000 + {1'b0, held_q, unit[9:0]};
          have_cp = 1'b1;
        end else begin
          invalid = 1'b1;
        end
      end else if (is_lead) begin
        if (last_unit_i) begin
          invalid  = 1'b1;
          end_lead = 1'b1;
        end else begin
          lead_d = 1'b1;
          held_d = unit[9:0];
        end
      end else begin
        have_cp = 1'b1;
      end

      if (invalid) begin
        sticky_d = 1'b1;
      end

      job_o.inv = sticky_q | invalid;
      job_o.eos = last_unit_i;

      if (have_cp) begin
        job_o.bytes      = enc.bytes;
        job_o.last_idx   = enc.last_idx;
        job_o.byte_valid = 1'b1;
        have_bytes       = 1'b1;
      end else if (invalid && cfg_i.mode == utt_pkg::ModeReplace) begin
        if (!end_lead) begin
          job_o.bytes      = cfg_i.repl_bytes;
          job_o.last_idx   = repl_last;
          job_o.byte_valid = 1'b1;
          have_bytes       = 1'b1;
        end
      end else if (invalid && cfg_i.mode != utt_pkg::ModeSkip) begin
        stop = 1'b1;
      end

      if (stop) begin
        job_o.stop = 1'b1;
        push_o     = accept;
        halted_d   = !last_unit_i;
      end else if (have_bytes || last_unit_i) begin
        push_o = accept;
      end
    end

    // every stream end clears the per-stream state
    if (last_unit_i) begin
      lead_d   = 1'b0;
      held_d   = '0;
      sticky_d = 1'b0;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= 1'b0;
      held_q   <= '0;
      sticky_q <= 1'b0;
      halted_q <= 1'b0;
    end else if (accept) begin
      lead_q   <= lead_d;
      held_q   <= held_d;
      sticky_q <= sticky_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ----- src/utt_job_fifo.sv -----
// Two-entry job queue between front end and byte sequencer.
// Depends on utt_pkg (job_t).
module utt_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utt_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output utt_pkg::job_t head_o
);

  utt_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- src/utt_back.sv -----
// Byte sequencer: walks the head job one byte per cycle, unless stalled, into the output register.
// Depends on utt_pkg (job_t).
module utt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  utt_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          byte_valid_o,
  output logic          last_of_run_o,
  output logic          invalid_seen_o,
  output logic          error_stop_o,
  output logic          end_of_stream_o
);

  logic [1:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] byte_q;
  logic       bvalid_q, lrun_q, inv_q, stop_q, eos_q;
  logic       load, is_last;

  assign load    = head_valid_i && (!ovalid_q || out_ready_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= head_i.bytes[idx_q];
      bvalid_q <= head_i.byte_valid;
      lrun_q   <= is_last;
      inv_q    <= head_i.inv;
      stop_q   <= head_i.stop;
      eos_q    <= head_i.eos;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign out_byte_o      = byte_q;
  assign byte_valid_o    = bvalid_q;
  assign last_of_run_o   = lrun_q;
  assign invalid_seen_o  = inv_q;
  assign error_stop_o    = stop_q;
  assign end_of_stream_o = eos_q;

endmodule
